FILE: hdl/krbc_pkg.sv
package krbc_pkg;

  localparam int unsigned KeyEntries = 256;
  localparam int unsigned IdxW       = $clog2(KeyEntries);
  localparam int unsigned ByteW      = 8;
  localparam int unsigned FuncW      = 2;
  localparam int unsigned PosW       = IdxW + 1;

  localparam logic [ByteW-1:0] MarkLow  = '0;
  localparam logic [ByteW-1:0] MarkHigh = ByteW'(KeyEntries - 1);
  localparam logic [PosW-1:0]  NotFound = PosW'(KeyEntries);

  typedef enum logic [FuncW-1:0] {
    FUNC_KEY_WRITE = 2'd0,
    FUNC_START     = 2'd1,
    FUNC_CODE      = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_KEY   = 8'b0000_0010,
    S_XOR   = 8'b0000_0100,
    S_RES   = 8'b0000_1000,
    S_XRD   = 8'b0001_0000,
    S_XLD   = 8'b0010_0000,
    S_SWEEP = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

endpackage

FILE: hdl/krbc_in_if.sv
interface krbc_in_if;
  import krbc_pkg::*;

  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [IdxW-1:0]  key_index;
  logic [ByteW-1:0] key_value;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, func, key_index, key_value, data_byte, input ready);
  modport sink (input valid, func, key_index, key_value, data_byte, output ready);
endinterface

FILE: hdl/krbc_out_if.sv
interface krbc_out_if;
  import krbc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] coded_byte;

  modport source (output valid, coded_byte, input ready);
  modport sink (input valid, coded_byte, output ready);
endinterface

FILE: hdl/keyed_rotor_byte_cipher_unit.sv
// Channel  Dir  Payload                                   Word accepted when
// in_i     in   func, key_index, key_value, data_byte     in_i.valid && in_i.ready
// out_o    out  coded_byte                                out_o.valid && out_o.ready
// cfg      in   cfg_wdata_i (decrypt_mode)                cfg_we_i
//
// A key write goes to the key RAM as it is accepted. A code word makes three dependent
// reads of the single-read-port key or inverse RAM and waits while the output register
// is still full. A start word adds a sweep that rebuilds the inverse RAM; every 256th
// code word adds, after its result, a mask read and a sweep that rewrites the key.
// Reset clears the counters, mode and control; the RAMs hold no reset value.
// Input is taken only when idle; a waiting result stalls only the next result stage.
module keyed_rotor_byte_cipher_unit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  krbc_in_if.sink    in_i,
  krbc_out_if.source out_o
);
  import krbc_pkg::*;

  state_e state_q, state_d;

  logic             decrypt_mode_q;
  logic [IdxW-1:0]  rotor_q, rotor_d;
  logic [ByteW-1:0] byte_in_block_q, byte_in_block_d;
  logic [ByteW-1:0] block_number_q, block_number_d;
  logic [ByteW-1:0] t_q, t_d;
  logic [ByteW-1:0] xv_q, xv_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic             start_q, start_d;
  logic             wr_pend_q;
  logic [IdxW-1:0]  wr_idx_q;
  logic [PosW-1:0]  first_q, first_d;
  logic [PosW-1:0]  second_q, second_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_data_q, out_data_d;

  logic             key_we, key_re, inv_we, inv_re;
  logic [IdxW-1:0]  key_waddr, key_raddr, inv_waddr, inv_raddr;
  logic [ByteW-1:0] key_wdata, inv_wdata, key_rdata, inv_rdata, tab_rdata;
  logic [ByteW-1:0] new_val;
  logic             accept, is_mark, slot_free;

  krbc_ram #(.Width(ByteW), .Depth(KeyEntries)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  krbc_ram #(.Width(IdxW), .Depth(KeyEntries)) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (inv_we),
    .waddr_i (inv_waddr),
    .wdata_i (inv_wdata),
    .re_i    (inv_re),
    .raddr_i (inv_raddr),
    .rdata_o (inv_rdata)
  );

  assign in_i.ready       = (state_q == S_IDLE);
  assign accept           = in_i.valid && in_i.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.coded_byte = out_data_q;
  assign slot_free        = !out_valid_q || out_o.ready;

  assign tab_rdata = decrypt_mode_q ? inv_rdata : key_rdata;

  // Write stage of the sweep: the entry read last cycle, XORed with the block value.
  assign new_val = key_rdata ^ xv_q;
  assign is_mark = wr_pend_q && (new_val == MarkLow || new_val == MarkHigh);

  always_comb begin
    key_we    = 1'b0;
    key_waddr = wr_idx_q;
    key_wdata = new_val;
    inv_we    = wr_pend_q;
    inv_waddr = IdxW'(new_val);
    inv_wdata = ByteW'(wr_idx_q);
    if (wr_pend_q) begin
      key_we = 1'b1;
    end else if (accept && in_i.func == FUNC_KEY_WRITE) begin
      key_we    = 1'b1;
      key_waddr = in_i.key_index;
      key_wdata = in_i.key_value;
    end
  end

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    if (is_mark) begin
      if (first_q == NotFound) begin
        first_d = {1'b0, wr_idx_q};
      end else if (second_q == NotFound) begin
        second_d = {1'b0, wr_idx_q};
      end
    end
  end

  always_comb begin
    state_d         = state_q;
    rotor_d         = rotor_q;
    byte_in_block_d = byte_in_block_q;
    block_number_d  = block_number_q;
    t_d             = t_q;
    xv_d            = xv_q;
    cnt_d           = cnt_q;
    start_d         = start_q;
    out_valid_d     = out_valid_q && !out_o.ready;
    out_data_d      = out_data_q;
    key_re          = 1'b0;
    key_raddr       = cnt_q;
    inv_re          = 1'b0;
    inv_raddr       = IdxW'(in_i.data_byte);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (in_i.func == FUNC_START) begin
            byte_in_block_d = '0;
            block_number_d  = '0;
            xv_d            = '0;
            cnt_d           = '0;
            start_d         = 1'b1;
            state_d         = S_SWEEP;
          end else if (in_i.func == FUNC_CODE) begin
            key_re    = !decrypt_mode_q;
            inv_re    = decrypt_mode_q;
            key_raddr = IdxW'(in_i.data_byte);
            state_d   = S_KEY;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_KEY: begin
        t_d       = tab_rdata;
        rotor_d   = rotor_q + 1'b1;
        key_re    = 1'b1;
        key_raddr = rotor_q + 1'b1;
        state_d   = S_XOR;
      end
      S_XOR: begin
        key_re    = !decrypt_mode_q;
        inv_re    = decrypt_mode_q;
        key_raddr = IdxW'(t_q ^ key_rdata);
        inv_raddr = IdxW'(t_q ^ key_rdata);
        state_d   = S_RES;
      end
      S_RES: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_data_d      = tab_rdata;
          byte_in_block_d = byte_in_block_q + 1'b1;
          state_d         = (byte_in_block_d == '0) ? S_XRD : S_IDLE;
        end
      end
      S_XRD: begin
        key_re    = 1'b1;
        key_raddr = IdxW'(block_number_q);
        state_d   = S_XLD;
      end
      S_XLD: begin
        xv_d    = key_rdata;
        cnt_d   = '0;
        start_d = 1'b0;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        key_re    = 1'b1;
        key_raddr = cnt_q;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == IdxW'(KeyEntries - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // The last entry is evaluated this cycle, so the rotor uses the next values.
        if (start_q) begin
          rotor_d = IdxW'(second_d - first_d - PosW'(1));
        end else begin
          block_number_d = block_number_q + 1'b1;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      decrypt_mode_q  <= 1'b0;
      rotor_q         <= '0;
      byte_in_block_q <= '0;
      block_number_q  <= '0;
      cnt_q           <= '0;
      start_q         <= 1'b0;
      wr_pend_q       <= 1'b0;
      first_q         <= NotFound;
      second_q        <= NotFound;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      if (cfg_we_i) begin
        decrypt_mode_q <= cfg_wdata_i;
      end
      rotor_q         <= rotor_d;
      byte_in_block_q <= byte_in_block_d;
      block_number_q  <= block_number_d;
      cnt_q           <= cnt_d;
      start_q         <= start_d;
      wr_pend_q       <= (state_q == S_SWEEP);
      out_valid_q     <= out_valid_d;
      if (accept && in_i.func == FUNC_START) begin
        first_q  <= NotFound;
        second_q <= NotFound;
      end else begin
        first_q  <= first_d;
        second_q <= second_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    xv_q       <= xv_d;
    wr_idx_q   <= cnt_q;
    out_data_q <= out_data_d;
  end

endmodule

FILE: hdl/krbc_ram.sv
module krbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: bench/krbc_checker.sv
module krbc_checker
  import krbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  krbc_in_if         in_mon_i,
  krbc_out_if        out_mon_i,
  output int         mismatches_o,
  output int         outstanding_o
);

  logic [ByteW-1:0] key_tbl [KeyEntries];
  logic [ByteW-1:0] inv_tbl [KeyEntries];
  logic [ByteW-1:0] rotor_pos;
  logic [ByteW-1:0] bytes_in_blk;
  logic [ByteW-1:0] blk_num;
  logic             decrypt_q;
  logic [ByteW-1:0] pending_coded [$];

  function automatic bit is_marker(logic [ByteW-1:0] v);
    return v == MarkLow || v == MarkHigh;
  endfunction

  // Ascending pass, so for a repeated value the highest position wins.
  function automatic void rebuild_inverse();
    for (int i = 0; i < KeyEntries; i++) inv_tbl[key_tbl[i]] = ByteW'(i);
  endfunction

  function automatic logic [ByteW-1:0] rotor_origin();
    int first;
    int second;
    first = 0;
    while (first < KeyEntries && !is_marker(key_tbl[first])) first++;
    second = (first < KeyEntries) ? first + 1 : KeyEntries;
    while (second < KeyEntries && !is_marker(key_tbl[second])) second++;
    return ByteW'(second - first - 1);
  endfunction

  function automatic logic [ByteW-1:0] cipher_byte(logic [ByteW-1:0] din);
    logic [ByteW-1:0] t;
    logic [ByteW-1:0] xv;
    t = decrypt_q ? inv_tbl[din] : key_tbl[din];
    rotor_pos = rotor_pos + 1'b1;
    t = t ^ key_tbl[rotor_pos];
    t = decrypt_q ? inv_tbl[t] : key_tbl[t];
    bytes_in_blk = bytes_in_blk + 1'b1;
    if (bytes_in_blk == '0) begin
      // The mask is taken before the sweep clears its own entry.
      xv = key_tbl[blk_num];
      for (int i = 0; i < KeyEntries; i++) key_tbl[i] = key_tbl[i] ^ xv;
      rebuild_inverse();
      blk_num = blk_num + 1'b1;
    end
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotor_pos = '0;
      bytes_in_blk = '0;
      blk_num = '0;
      decrypt_q = 1'b0;
      pending_coded.delete();
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) decrypt_q = cfg_wdata_i;

      if (out_mon_i.valid && out_mon_i.ready) begin
        if (pending_coded.size() == 0) begin
          $error("coded_byte: expected no word, got %02h", out_mon_i.coded_byte);
          mismatches_o++;
        end else if (out_mon_i.coded_byte !== pending_coded[0]) begin
          $error("coded_byte: expected %02h, got %02h", pending_coded[0],
                 out_mon_i.coded_byte);
          mismatches_o++;
          void'(pending_coded.pop_front());
        end else begin
          void'(pending_coded.pop_front());
        end
      end

      if (in_mon_i.valid && in_mon_i.ready) begin
        case (func_e'(in_mon_i.func))
          FUNC_KEY_WRITE: key_tbl[in_mon_i.key_index] = in_mon_i.key_value;
          FUNC_START: begin
            bytes_in_blk = '0;
            blk_num = '0;
            rebuild_inverse();
            rotor_pos = rotor_origin();
          end
          FUNC_CODE: pending_coded.push_back(cipher_byte(in_mon_i.data_byte));
          default: ;
        endcase
      end

      outstanding_o = pending_coded.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import krbc_pkg::*;

  localparam int SettleCycles = 300;
  localparam int QuietLimit   = 4000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles;
  int   send_idle_pct;
  int   stall_pct;

  logic [ByteW-1:0] holder_of [KeyEntries];

  krbc_in_if  in_if ();
  krbc_out_if out_if ();

  keyed_rotor_byte_cipher_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  krbc_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is
  // taken, with valid still high so back-to-back words need no extra step.
  task automatic send_word(func_e f, logic [IdxW-1:0] idx, logic [ByteW-1:0] val,
                           logic [ByteW-1:0] data);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= f;
    in_if.key_index <= idx;
    in_if.key_value <= val;
    in_if.data_byte <= data;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic send_code(logic [ByteW-1:0] data);
    send_word(FUNC_CODE, IdxW'($urandom), ByteW'($urandom), data);
  endtask

  task automatic send_start();
    send_word(FUNC_START, IdxW'($urandom), ByteW'($urandom), ByteW'($urandom));
  endtask

  task automatic load_permutation();
    logic [ByteW-1:0] perm [KeyEntries];
    logic [ByteW-1:0] t;
    int j;
    for (int i = 0; i < KeyEntries; i++) perm[i] = ByteW'(i);
    for (int i = KeyEntries - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < KeyEntries; i++) begin
      send_word(FUNC_KEY_WRITE, IdxW'(i), perm[i], ByteW'($urandom));
      holder_of[perm[i]] = ByteW'(i);
    end
  endtask

  // A key write or a start leaves no result behind, so a sweep may still be
  // running once the last result is out.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int pick;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = FUNC_NONE;
    in_if.key_index  = '0;
    in_if.key_value  = '0;
    in_if.data_byte  = '0;
    out_if.ready     = 1'b0;
    quiet_cycles     = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The whole key is written before anything reads it.
    load_permutation();
    send_start();
    send_code(8'h00);
    send_code(8'hFF);
    send_code(8'h5A);
    send_code(8'hA5);
    send_word(FUNC_NONE, 8'hFF, 8'hFF, 8'hFF);

    // No marker left anywhere; the key now repeats a value.
    send_word(FUNC_KEY_WRITE, holder_of[MarkLow], 8'h01, 8'h00);
    send_word(FUNC_KEY_WRITE, holder_of[MarkHigh], 8'h01, 8'h00);
    send_start();
    send_code(8'h3C);
    send_code(8'hC3);
    // A single marker at the last position, so the second search finds none.
    send_word(FUNC_KEY_WRITE, 8'hFF, MarkHigh, 8'h00);
    send_start();
    send_code(8'h81);
    // Markers at both ends of the key.
    send_word(FUNC_KEY_WRITE, 8'h00, MarkLow, 8'h00);
    send_start();
    send_code(8'h7E);
    // Adjacent markers.
    send_word(FUNC_KEY_WRITE, 8'h01, MarkHigh, 8'h00);
    send_start();
    send_code(8'h18);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      send_idle_pct = (ph == 1) ? 69 : (ph == 3) ? 26 : 0;
      stall_pct     = (ph == 2) ? 69 : (ph == 3) ? 26 : 0;
      write_mode(ph[0]);
      if (ph == 0) begin
        send_start();
      end
      // Only the first phase starts a stream, so that it runs past a block end.
      for (int n = 0; n < 95; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
          send_code(ByteW'($urandom));
        end else if (pick < 94) begin
          send_word(FUNC_KEY_WRITE, IdxW'($urandom), ByteW'($urandom), ByteW'($urandom));
        end else begin
          send_word(FUNC_NONE, IdxW'($urandom), ByteW'($urandom), ByteW'($urandom));
        end
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
